// File: sv/pcm_pkg.sv
// ----------------------------------------------------------------------------
// Pad coordinate mapper package
// Opcodes, range limits, request and result records, small lookup functions.
// ----------------------------------------------------------------------------
package pcm_pkg;

  // Conversion opcodes
  localparam logic [2:0] OP_HW2PAD  = 3'd0;
  localparam logic [2:0] OP_PAD2HW  = 3'd1;
  localparam logic [2:0] OP_MOD2PAD = 3'd2;
  localparam logic [2:0] OP_PAD2MOD = 3'd3;
  localparam logic [2:0] OP_MOD2HW  = 3'd4;
  localparam logic [2:0] OP_HW2MOD  = 3'd5;

  // Range limits (exclusive; the Max values are inclusive), cathode flip and bad pad word
  localparam logic [3:0] NumLinks    = 4'd14;
  localparam logic [4:0] NumColumns  = 5'd24;
  localparam logic [3:0] NumChips    = 4'd10;
  localparam logic [5:0] NumChannels = 6'd48;
  localparam logic [3:0] NumModules  = 4'd7;
  localparam logic [3:0] NumCathodes = 4'd6;
  localparam logic [7:0] CathX       = 8'd80;
  localparam logic [7:0] CathY       = 8'd48;
  localparam logic [7:0] CathXMax    = 8'd79;
  localparam logic [7:0] CathYMax    = 8'd47;
  localparam logic [7:0] ModX        = 8'd160;
  localparam logic [7:0] ModY        = 8'd144;
  localparam logic [3:0] CathFlip    = 4'd5;
  localparam logic [31:0] BadPad     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  link;
    logic [4:0]  column;
    logic [3:0]  chip;
    logic [5:0]  channel;
    logic [23:0] pad;
    logic [2:0]  mod_num;
    logic [7:0]  mod_x;
    logic [7:0]  mod_y;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [23:0] pad;
  } pad_res_t;

  typedef struct packed {
    logic [31:0] pad;
    logic [3:0]  link;
    logic [4:0]  column;
    logic [3:0]  chip;
    logic [5:0]  channel;
    logic [2:0]  mod_num;
    logic [7:0]  mod_x;
    logic [7:0]  mod_y;
    logic        error;
  } res_t;

  // Quotient by six via reciprocal 43/256, exact for values below 48
  function automatic logic [2:0] div6_f(input logic [5:0] v);
    logic [11:0] prod;
    prod = {6'd0, v} * 12'd43;
    return prod[10:8];
  endfunction

  function automatic logic [2:0] mod6_f(input logic [5:0] v);
    logic [5:0] r;
    r = v - ({3'd0, div6_f(v)} * 6'd6);
    return r[2:0];
  endfunction

  function automatic logic [2:0] chan_to_row_f(input logic [2:0] r);
    logic [2:0] o;
    case (r)
      3'd0:    o = 3'd3;
      3'd1:    o = 3'd2;
      3'd2:    o = 3'd4;
      3'd3:    o = 3'd1;
      3'd4:    o = 3'd5;
      3'd5:    o = 3'd0;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

  function automatic logic [2:0] row_to_chan_f(input logic [2:0] r);
    logic [2:0] o;
    case (r)
      3'd0:    o = 3'd5;
      3'd1:    o = 3'd3;
      3'd2:    o = 3'd1;
      3'd3:    o = 3'd0;
      3'd4:    o = 3'd2;
      3'd5:    o = 3'd4;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

endpackage

// File: sv/pcm_if.sv
// ----------------------------------------------------------------------------
// Pad coordinate mapper channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [3:0]  link_in;
  logic [4:0]  column_in;
  logic [3:0]  chip_in;
  logic [5:0]  channel_in;
  logic [23:0] pad_in;
  logic [2:0]  module_in;
  logic [7:0]  mod_x_in;
  logic [7:0]  mod_y_in;

  modport source (output valid, opcode, link_in, column_in, chip_in, channel_in,
                  pad_in, module_in, mod_x_in, mod_y_in, input ready);
  modport sink   (input valid, opcode, link_in, column_in, chip_in, channel_in,
                  pad_in, module_in, mod_x_in, mod_y_in, output ready);
endinterface

interface pcm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pad_out;
  logic [3:0]  link_out;
  logic [4:0]  column_out;
  logic [3:0]  chip_out;
  logic [5:0]  channel_out;
  logic [2:0]  module_out;
  logic [7:0]  mod_x_out;
  logic [7:0]  mod_y_out;
  logic        error;

  modport source (output valid, pad_out, link_out, column_out, chip_out, channel_out,
                  module_out, mod_x_out, mod_y_out, error, input ready);
  modport sink   (input valid, pad_out, link_out, column_out, chip_out, channel_out,
                  module_out, mod_x_out, mod_y_out, error, output ready);
endinterface

// File: sv/pad_coordinate_mapper.sv
// ----------------------------------------------------------------------------
// Pad coordinate mapper
// Converts pad addresses between hardware, pad word and module coordinates.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  in_i     | in  | valid/ready  | opcode, hardware tuple, pad word, module x/y
//  out_o    | out | valid/ready  | pad word, hardware tuple, module x/y, error
//
//  One request per cycle unless stalled; held in request, then result register.
//  The conversion is a single pass of constant-divide and table logic.
//  Reset clears both valid flags; the request and result data are not reset.
//  A stalled result holds in the result register while one more request waits
//  in the request register; ready drops only when both are full.
// ----------------------------------------------------------------------------
module pad_coordinate_mapper
  import pcm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  pcm_in_if.sink    in_i,
  pcm_out_if.source out_o
);

  logic     a_vld_q, a_vld_d, a_rdy;
  logic     b_vld_q, b_vld_d, b_rdy;
  req_t     req_d, req_q;
  res_t     res_d, res_q;
  pad_res_t pad_w;

  assign b_rdy      = !b_vld_q || out_o.ready;
  assign a_rdy      = !a_vld_q || b_rdy;
  assign in_i.ready = a_rdy;

  assign req_d = '{opcode:  in_i.opcode,    link:    in_i.link_in,
                   column:  in_i.column_in, chip:    in_i.chip_in,
                   channel: in_i.channel_in, pad:    in_i.pad_in,
                   mod_num: in_i.module_in, mod_x:   in_i.mod_x_in,
                   mod_y:   in_i.mod_y_in};

  pcm_to_pad u_to_pad (
    .req_i (req_q),
    .pad_o (pad_w)
  );

  pcm_from_pad u_from_pad (
    .opcode_i (req_q.opcode),
    .pad_i    (pad_w),
    .res_o    (res_d)
  );

  // Advance each stage when the one downstream has room
  assign a_vld_d = a_rdy ? in_i.valid : a_vld_q;
  assign b_vld_d = b_rdy ? a_vld_q : b_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= a_vld_d;
      b_vld_q <= b_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && a_rdy) begin
      req_q <= req_d;
    end
    if (a_vld_q && b_rdy) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = b_vld_q;
  assign out_o.pad_out     = res_q.pad;
  assign out_o.link_out    = res_q.link;
  assign out_o.column_out  = res_q.column;
  assign out_o.chip_out    = res_q.chip;
  assign out_o.channel_out = res_q.channel;
  assign out_o.module_out  = res_q.mod_num;
  assign out_o.mod_x_out   = res_q.mod_x;
  assign out_o.mod_y_out   = res_q.mod_y;
  assign out_o.error       = res_q.error;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> a_vld_q)
    else $error("accepted request not held in request register");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q && !b_rdy |=> a_vld_q && $stable(req_q))
    else $error("waiting request lost under result stall");

  a_error_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.error |-> out_o.pad_out == BadPad && out_o.link_out == 4'd0 &&
      out_o.mod_x_out == 8'd0 && out_o.mod_y_out == 8'd0 && out_o.channel_out == 6'd0)
    else $error("error result carries coordinates");

  a_good_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.error |-> out_o.pad_out[31:24] == 8'd0)
    else $error("valid result pad word out of 24 bits");

endmodule

// File: sv/pcm_to_pad.sv
// ----------------------------------------------------------------------------
// Pad coordinate mapper: front conversion
// Range checks the source system and forms the packed pad word.
// ----------------------------------------------------------------------------
module pcm_to_pad
  import pcm_pkg::*;
(
  input  req_t     req_i,
  output pad_res_t pad_o
);

  logic       hw_ok, mod_ok, pad_ok;
  logic [2:0] chan_div, chan_rem;
  logic [3:0] hw_pc;
  logic [7:0] hw_px, hw_py;
  logic [23:0] hw_pad;
  logic [1:0] y_seg;
  logic       x_hi;
  logic [7:0] m_px, m_py;
  logic [23:0] mod_pad;

  assign hw_ok = (req_i.link < NumLinks) && (req_i.column < NumColumns) &&
                 (req_i.chip < NumChips) && (req_i.channel < NumChannels);
  assign mod_ok = ({1'b0, req_i.mod_num} < NumModules) && (req_i.mod_x < ModX) &&
                  (req_i.mod_y < ModY);
  assign pad_ok = (req_i.pad[23:20] < NumModules) && (req_i.pad[19:16] < NumCathodes) &&
                  (req_i.pad[15:8] < CathX) && (req_i.pad[7:0] < CathY);

  // Hardware tuple to pad; even links mirror cathode and y
  always_comb begin
    chan_div = div6_f(req_i.channel);
    chan_rem = mod6_f(req_i.channel);
    hw_pc    = {1'b0, req_i.column[4:3], 1'b1};
    hw_px    = CathXMax - ({1'b0, req_i.chip, 3'b000} + {5'd0, chan_div});
    hw_py    = ({5'd0, req_i.column[2:0]} * 8'd6) + {5'd0, chan_to_row_f(chan_rem)};
    if (!req_i.link[0]) begin
      hw_pc = CathFlip - hw_pc;
      hw_py = CathYMax - hw_py;
    end
    hw_pad = {1'b0, req_i.link[3:1], hw_pc, hw_px, hw_py};
  end

  // Module coordinates to pad
  always_comb begin
    if (req_i.mod_y >= 8'd96) begin
      y_seg = 2'd2;
      m_py  = req_i.mod_y - 8'd96;
    end else if (req_i.mod_y >= CathY) begin
      y_seg = 2'd1;
      m_py  = req_i.mod_y - CathY;
    end else begin
      y_seg = 2'd0;
      m_py  = req_i.mod_y;
    end
    x_hi    = (req_i.mod_x >= CathX);
    m_px    = x_hi ? (req_i.mod_x - CathX) : req_i.mod_x;
    mod_pad = {1'b0, req_i.mod_num, 1'b0, y_seg, x_hi, m_px, m_py};
  end

  always_comb begin
    unique case (req_i.opcode)
      OP_HW2PAD, OP_HW2MOD: begin
        pad_o.ok  = hw_ok;
        pad_o.pad = hw_pad;
      end
      OP_PAD2HW, OP_PAD2MOD: begin
        pad_o.ok  = pad_ok;
        pad_o.pad = req_i.pad;
      end
      OP_MOD2PAD, OP_MOD2HW: begin
        pad_o.ok  = mod_ok;
        pad_o.pad = mod_pad;
      end
      default: begin
        pad_o.ok  = 1'b0;
        pad_o.pad = req_i.pad;
      end
    endcase
  end

endmodule

// File: sv/pcm_from_pad.sv
// ----------------------------------------------------------------------------
// Pad coordinate mapper: back conversion
// Expands a checked pad word into the target system and assembles the result.
// ----------------------------------------------------------------------------
module pcm_from_pad
  import pcm_pkg::*;
(
  input  logic [2:0] opcode_i,
  input  pad_res_t   pad_i,
  output res_t       res_o
);

  logic [3:0] ch, pc, pc_m;
  logic [7:0] px, py, px_m, py_m;
  logic       even;
  logic [3:0] link;
  logic [4:0] column;
  logic [3:0] chip;
  logic [5:0] channel;
  logic [7:0] mod_x, mod_y;

  assign ch   = pad_i.pad[23:20];
  assign pc   = pad_i.pad[19:16];
  assign px   = pad_i.pad[15:8];
  assign py   = pad_i.pad[7:0];
  assign even = !pc[0];

  // Pad to hardware: cathode parity picks the link and undoes the mirror
  assign px_m    = CathXMax - px;
  assign py_m    = even ? (CathYMax - py) : py;
  assign pc_m    = even ? (CathFlip - pc) : pc;
  assign link    = {ch[2:0], !even};
  assign column  = {pc_m[2:1], 3'b000} + {2'd0, div6_f(py_m[5:0])};
  assign chip    = px_m[6:3];
  assign channel = ({3'd0, px_m[2:0]} * 6'd6) + {3'd0, row_to_chan_f(mod6_f(py_m[5:0]))};

  // Pad to module
  assign mod_x = px + (pc[0] ? CathX : 8'd0);
  assign mod_y = ({6'd0, pc[2:1]} * CathY) + py;

  always_comb begin
    res_o       = '0;
    res_o.pad   = {8'd0, pad_i.pad};
    if (!pad_i.ok) begin
      res_o.pad   = BadPad;
      res_o.error = 1'b1;
    end else begin
      case (opcode_i)
        OP_PAD2HW, OP_MOD2HW: begin
          res_o.link    = link;
          res_o.column  = column;
          res_o.chip    = chip;
          res_o.channel = channel;
        end
        OP_PAD2MOD, OP_HW2MOD: begin
          res_o.mod_num = ch[2:0];
          res_o.mod_x   = mod_x;
          res_o.mod_y   = mod_y;
        end
        default: ;
      endcase
    end
  end

endmodule
